// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

	localparam int DATA_BITS = 32;
	localparam int CAP_BITS  = 5;
	localparam int CAP_RESET = 16;

	// Value returned for a get that misses and for every put.
	localparam logic [DATA_BITS-1:0] READ_MISS = '1;

	// Request operations.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Register indexes of the configuration port.
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic capture;  // latch the incoming request
		logic compare;  // tag compare and victim selection
		logic update;   // write table, load result register
		logic clear;    // invalidate every entry
	} lkv_cmd_t;

endpackage

// ===== rtl/lkv_ram.sv =====
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/lkv_ctrl.sv =====
module lkv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  logic             clear_req,
	output lkv_pkg::lkv_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.compare = (state_q == ST_CMP);
		cmd.update  = (state_q == ST_UPD) && out_free;
		cmd.clear   = clear_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// In the update state a free output register is reloaded below.
			if (out_valid_q && !out_stall && (state_q != ST_UPD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					// The result waits here until the output register is free.
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/lkv_dp.sv =====
module lkv_dp #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lkv_pkg::lkv_cmd_t                 cmd,
	input  logic [lkv_pkg::CAP_BITS-1:0]      capacity,
	input  logic                              opcode,
	input  logic [lkv_pkg::DATA_BITS-1:0]     key,
	input  logic [lkv_pkg::DATA_BITS-1:0]     value,
	output logic [lkv_pkg::DATA_BITS-1:0]     read_value,
	output logic                              hit,
	output logic                              evicted,
	output logic [lkv_pkg::DATA_BITS-1:0]     evicted_key
);

	localparam int KW = (KEY_BITS < lkv_pkg::DATA_BITS) ? KEY_BITS : lkv_pkg::DATA_BITS;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// Request capture.
	logic                          op_s1;
	logic [KW-1:0]                 key_s1;
	logic [lkv_pkg::DATA_BITS-1:0] value_s1;

	// Tag store and recency ranks; rank 0 is the most recent entry.
	logic [KW-1:0] key_q   [ENTRIES];
	logic [IW-1:0] rank_q  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0] count_q;

	// Compare results.
	logic [IW-1:0] slot_s2;
	logic [CW-1:0] limit_s2;
	logic          hit_s2;
	logic          evict_s2;
	logic          write_s2;
	logic [KW-1:0] evkey_s2;

	// Result register.
	logic [lkv_pkg::DATA_BITS-1:0] read_value_q;
	logic                          hit_q;
	logic                          evicted_q;
	logic [lkv_pkg::DATA_BITS-1:0] evicted_key_q;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] oldest;
	logic [IW-1:0]      found_idx;
	logic [IW-1:0]      oldest_idx;
	logic [IW-1:0]      free_idx;
	logic               hit_c;
	logic               full_c;
	logic [CW-1:0]      eff_cap;
	logic [lkv_pkg::DATA_BITS-1:0] ram_rdata;

	assign read_value  = read_value_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	always_comb begin
		if (capacity == '0) begin
			eff_cap = CW'(1);
		end else if (int'(capacity) > ENTRIES) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(capacity);
		end
	end

	always_comb begin
		found_idx  = '0;
		oldest_idx = '0;
		free_idx   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == key_s1);
			// Ranks of valid entries run 0 .. count-1, so the oldest holds count-1.
			oldest[i] = valid_q[i] && (CW'(rank_q[i]) == count_q - CW'(1));
			if (match[i]) begin
				found_idx = found_idx | IW'(i);
			end
			if (oldest[i]) begin
				oldest_idx = oldest_idx | IW'(i);
			end
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
		hit_c  = |match;
		full_c = (count_q >= eff_cap);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1    <= opcode;
			key_s1   <= key[KW-1:0];
			value_s1 <= value;
		end
		if (cmd.compare) begin
			hit_s2   <= hit_c;
			evict_s2 <= !hit_c && (op_s1 == lkv_pkg::OP_PUT) && full_c;
			write_s2 <= hit_c || (op_s1 == lkv_pkg::OP_PUT);
			evkey_s2 <= key_q[oldest_idx];
			if (hit_c) begin
				slot_s2  <= found_idx;
				limit_s2 <= CW'(rank_q[found_idx]);
			end else if (full_c) begin
				slot_s2  <= oldest_idx;
				limit_s2 <= count_q - CW'(1);
			end else begin
				slot_s2  <= free_idx;
				limit_s2 <= count_q;
			end
		end
		if (cmd.update) begin
			read_value_q  <= (hit_s2 && (op_s1 == lkv_pkg::OP_GET)) ? ram_rdata
				: lkv_pkg::READ_MISS;
			hit_q         <= hit_s2;
			evicted_q     <= evict_s2;
			evicted_key_q <= evict_s2 ? lkv_pkg::DATA_BITS'(evkey_s2) : '0;
			if (write_s2) begin
				key_q[slot_s2] <= key_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.update && write_s2) begin
			// Entries younger than the touched one age by one step.
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && (CW'(rank_q[i]) < limit_s2)) begin
					rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
			rank_q[slot_s2]  <= '0;
			valid_q[slot_s2] <= 1'b1;
			if (!hit_s2 && !evict_s2) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	lkv_ram #(
		.WIDTH(lkv_pkg::DATA_BITS),
		.DEPTH(ENTRIES)
	) u_value_ram (
		.clk  (clk),
		.we   (cmd.update && write_s2 && (op_s1 == lkv_pkg::OP_PUT)),
		.waddr(slot_s2),
		.wdata(value_s1),
		.raddr(found_idx),
		.rdata(ram_rdata)
	);

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Requests arrive on the input channel (in_valid, in_stall, opcode, key, value):
// a get returns the stored value with hit set, or all ones on a miss; a put
// updates a present key or inserts a new one, evicting the least recently used
// entry and reporting its key once capacity_in_use entries are held.
// Every request produces exactly one result on the output channel
// (out_valid, out_stall, read_value, hit, evicted, evicted_key).
// A result follows its request in order: the accepting edge captures the
// request, the compare state does the parallel key compare, value RAM read
// and victim choice, and the update state updates the table and loads the
// result register once the output register is free. The next request is
// taken in the cycle after the result is loaded; no new request is accepted
// while the previous one is in its compare or update step.
// A held result does not block the next request from being accepted and
// compared; it only holds that request in its update step until taken.
// Reset and any write to capacity_in_use (address 0) empty the table; reset
// sets capacity_in_use to 16. No clearing pass is needed.
module lru_key_value_cache #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic        hit,
	output logic        evicted,
	output logic [31:0] evicted_key
);

	logic [lkv_pkg::CAP_BITS-1:0] capacity_q;
	logic                         cap_write;
	lkv_pkg::lkv_cmd_t            cmd;

	assign pready    = 1'b1;
	assign cap_write = psel && penable && pwrite && (paddr[2] == lkv_pkg::REG_CAPACITY);
	assign prdata    = (paddr[2] == lkv_pkg::REG_CAPACITY) ? 32'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
		end else if (cap_write) begin
			capacity_q <= pwdata[lkv_pkg::CAP_BITS-1:0];
		end
	end

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.clear_req(cap_write),
		.cmd      (cmd)
	);

	lkv_dp #(
		.ENTRIES (ENTRIES),
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.capacity   (capacity_q),
		.opcode     (opcode),
		.key        (key),
		.value      (value),
		.read_value (read_value),
		.hit        (hit),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);

endmodule
